FILE: rtl/core/linear_regression_gradient_step_macros.svh
// Assertion macros for the checker file.
`ifndef LINEAR_REGRESSION_GRADIENT_STEP_MACROS_SVH
`define LINEAR_REGRESSION_GRADIENT_STEP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRGS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LRGS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/lrgs_pkg.sv
package lrgs_pkg;

	localparam int unsigned MAX_SAMPLES_DEF   = 64;
	localparam logic [31:0] LEARNING_RATE_RST = 32'd429497;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_STEP  = 2'd2
	} action_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL_P0,
		ST_MUL_P1,
		ST_ERROR,
		ST_MUL_SQ,
		ST_MUL_G0,
		ST_MUL_G1,
		ST_ACCUM,
		ST_DIV_LOAD,
		ST_DIV_RUN,
		ST_DIV_STORE,
		ST_UPD_HI,
		ST_UPD_LO,
		ST_UPD_NEW
	} state_t;

	typedef enum logic [1:0] {
		DIV_COST,
		DIV_GRAD0,
		DIV_GRAD1
	} div_sel_t;

endpackage

FILE: rtl/core/linear_regression_gradient_step.sv
// Channel        | Handshake                  | Payload
// request        | start, accepted when !busy | action, feature_0, feature_1, target
// result         | done, one cycle strobe     | step_number, cost, new_weight_0,
//                |                            | new_weight_1, status
// configuration  | learning_rate_we           | learning_rate
//
// Load, clear and ignored requests complete at the accepting edge and never raise busy.
// A step over m stored samples passes each sample in turn through the shared 33x33
// multiplier, then runs three 64-step bit-serial divisions: the cost sum by 2*m and the
// two gradient sums by m. A step with no samples answers on the next cycle.
// Reset clears the sample count, weights and iteration count and restores the default
// learning rate.
// The receiver cannot stall; done marks each result for exactly one cycle.
module linear_regression_gradient_step #(
	parameter int unsigned MAX_SAMPLES = lrgs_pkg::MAX_SAMPLES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic signed [31:0] feature_0,
	input  logic signed [31:0] feature_1,
	input  logic signed [31:0] target,
	input  logic               learning_rate_we,
	input  logic [31:0]        learning_rate,
	output logic               done,
	output logic [31:0]        step_number,
	output logic [62:0]        cost,
	output logic signed [31:0] new_weight_0,
	output logic signed [31:0] new_weight_1,
	output logic               status
);
	import lrgs_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int unsigned DIV_W = CNT_W + 1;
	localparam int unsigned ACC_W = 64 + $clog2(MAX_SAMPLES) + 1;

	function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
		if (v > 67'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -67'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	state_t state_q, state_d;

	logic [CNT_W-1:0] count_q, idx_q;
	logic [95:0] mem [MAX_SAMPLES];
	logic [95:0] rd_q;
	logic signed [31:0] w0_q, w1_q;
	logic [31:0] iter_q, lr_q;
	logic done_q, status_q;
	div_sel_t dsel_q;
	logic widx_q;
	logic [5:0] dcnt_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_q, hi_q, p0_q;
	logic signed [31:0] e_q, e_sat;
	logic signed [ACC_W-1:0] sq_q, g0_q, g1_q;
	logic [DIV_W-1:0] rem_q, rem_nx, div_d;
	logic [63:0] quo_q, div_n, qres;
	logic neg_q, div_neg, ge;
	logic [DIV_W:0] trial, trial_sub;
	logic [62:0] cost_q;
	logic signed [63:0] grad0_q, grad1_q, grad_sel;

	logic signed [31:0] f0, f1, y, wsel, nw;
	logic signed [66:0] hsum, hval, diff, delta, nw_full;
	logic signed [ACC_W-17:0] sq_t, g0_t, g1_t;
	logic signed [63:0] sq_s, g0_s, g1_s;
	logic last, can_load;

	assign f0 = rd_q[31:0];
	assign f1 = rd_q[63:32];
	assign y  = rd_q[95:64];

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign cost         = cost_q;
	assign step_number  = iter_q;
	assign new_weight_0 = w0_q;
	assign new_weight_1 = w1_q;

	assign last     = (CNT_W'(idx_q + 1'b1) == count_q);
	assign can_load = (count_q < CNT_W'(MAX_SAMPLES));
	assign grad_sel = widx_q ? grad1_q : grad0_q;
	assign wsel     = widx_q ? w1_q : w0_q;

	assign hsum  = 67'(p0_q) + 67'(mul_q);
	assign hval  = hsum >>> 16;
	assign diff  = hval - 67'(y);
	assign e_sat = sat32(diff);

	assign sq_t = sq_q[ACC_W-1:16];
	assign g0_t = g0_q[ACC_W-1:16];
	assign g1_t = g1_q[ACC_W-1:16];
	assign sq_s = 64'(sq_t);
	assign g0_s = 64'(g0_t);
	assign g1_s = 64'(g1_t);

	always_comb begin
		div_n   = sq_s;
		div_neg = 1'b0;
		div_d   = {count_q, 1'b0};
		unique case (dsel_q)
			DIV_GRAD0: begin
				div_neg = g0_s[63];
				div_n   = g0_s[63] ? -g0_s : g0_s;
				div_d   = {1'b0, count_q};
			end
			DIV_GRAD1: begin
				div_neg = g1_s[63];
				div_n   = g1_s[63] ? -g1_s : g1_s;
				div_d   = {1'b0, count_q};
			end
			default: begin
			end
		endcase
	end

	assign trial     = {rem_q, quo_q[63]};
	assign trial_sub = trial - {1'b0, div_d};
	assign ge        = (trial >= {1'b0, div_d});
	assign rem_nx    = ge ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
	assign qres      = neg_q ? -quo_q : quo_q;

	assign delta   = 67'(hi_q) + 67'(mul_q >>> 32);
	assign nw_full = 67'(wsel) - delta;
	assign nw      = sat32(nw_full);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MUL_P0: begin
				mul_a = 33'(f0);
				mul_b = 33'(w0_q);
			end
			ST_MUL_P1: begin
				mul_a = 33'(f1);
				mul_b = 33'(w1_q);
			end
			ST_MUL_SQ: begin
				mul_a = 33'(e_q);
				mul_b = 33'(e_q);
			end
			ST_MUL_G0: begin
				mul_a = 33'(e_q);
				mul_b = 33'(f0);
			end
			ST_MUL_G1: begin
				mul_a = 33'(e_q);
				mul_b = 33'(f1);
			end
			ST_UPD_HI: begin
				mul_a = 33'(signed'(grad_sel[63:32]));
				mul_b = {1'b0, lr_q};
			end
			ST_UPD_LO: begin
				mul_a = {1'b0, grad_sel[31:0]};
				mul_b = {1'b0, lr_q};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && action == ACT_STEP && count_q != '0) begin
					state_d = ST_READ;
				end
			end
			ST_READ:      state_d = ST_MUL_P0;
			ST_MUL_P0:    state_d = ST_MUL_P1;
			ST_MUL_P1:    state_d = ST_ERROR;
			ST_ERROR:     state_d = ST_MUL_SQ;
			ST_MUL_SQ:    state_d = ST_MUL_G0;
			ST_MUL_G0:    state_d = ST_MUL_G1;
			ST_MUL_G1:    state_d = ST_ACCUM;
			ST_ACCUM:     state_d = last ? ST_DIV_LOAD : ST_READ;
			ST_DIV_LOAD:  state_d = ST_DIV_RUN;
			ST_DIV_RUN:   state_d = (dcnt_q == '0) ? ST_DIV_STORE : ST_DIV_RUN;
			ST_DIV_STORE: state_d = (dsel_q == DIV_GRAD1) ? ST_UPD_HI : ST_DIV_LOAD;
			ST_UPD_HI:    state_d = ST_UPD_LO;
			ST_UPD_LO:    state_d = ST_UPD_NEW;
			ST_UPD_NEW:   state_d = widx_q ? ST_IDLE : ST_UPD_HI;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			idx_q    <= '0;
			w0_q     <= '0;
			w1_q     <= '0;
			iter_q   <= '0;
			lr_q     <= LEARNING_RATE_RST;
			done_q   <= 1'b0;
			status_q <= 1'b0;
			dsel_q   <= DIV_COST;
			widx_q   <= 1'b0;
			dcnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (learning_rate_we) begin
				lr_q <= learning_rate;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						unique case (action)
							ACT_LOAD: begin
								if (can_load) begin
									count_q <= CNT_W'(count_q + 1'b1);
								end
							end
							ACT_CLEAR: begin
								count_q <= '0;
								w0_q    <= '0;
								w1_q    <= '0;
								iter_q  <= '0;
							end
							ACT_STEP: begin
								idx_q  <= '0;
								dsel_q <= DIV_COST;
								widx_q <= 1'b0;
								if (count_q == '0) begin
									done_q   <= 1'b1;
									status_q <= 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_ACCUM:    idx_q  <= CNT_W'(idx_q + 1'b1);
				ST_DIV_LOAD: dcnt_q <= '1;
				ST_DIV_RUN:  dcnt_q <= dcnt_q - 1'b1;
				ST_DIV_STORE: begin
					unique case (dsel_q)
						DIV_COST:  dsel_q <= DIV_GRAD0;
						DIV_GRAD0: dsel_q <= DIV_GRAD1;
						default:   dsel_q <= DIV_GRAD1;
					endcase
				end
				ST_UPD_NEW: begin
					if (widx_q) begin
						w1_q     <= nw;
						iter_q   <= iter_q + 1'b1;
						done_q   <= 1'b1;
						status_q <= 1'b0;
					end else begin
						w0_q   <= nw;
						widx_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_q  <= mem[idx_q[AW-1:0]];
		mul_q <= mul_a * mul_b;
		if (state_q == ST_IDLE && start && action == ACT_LOAD && can_load) begin
			mem[count_q[AW-1:0]] <= {target, feature_1, feature_0};
		end
		unique case (state_q)
			ST_IDLE: begin
				if (start && action == ACT_STEP) begin
					sq_q   <= '0;
					g0_q   <= '0;
					g1_q   <= '0;
					cost_q <= '0;
				end
			end
			ST_MUL_P1: p0_q <= mul_q;
			ST_ERROR:  e_q  <= e_sat;
			ST_MUL_G0: sq_q <= sq_q + ACC_W'(mul_q);
			ST_MUL_G1: g0_q <= g0_q + ACC_W'(mul_q);
			ST_ACCUM:  g1_q <= g1_q + ACC_W'(mul_q);
			ST_DIV_LOAD: begin
				quo_q <= div_n;
				rem_q <= '0;
				neg_q <= div_neg;
			end
			ST_DIV_RUN: begin
				rem_q <= rem_nx;
				quo_q <= {quo_q[62:0], ge};
			end
			ST_DIV_STORE: begin
				unique case (dsel_q)
					DIV_COST:  cost_q  <= qres[62:0];
					DIV_GRAD0: grad0_q <= qres;
					default:   grad1_q <= qres;
				endcase
			end
			ST_UPD_LO: hi_q <= mul_q;
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/core/lrgs_checker.sv
`include "linear_regression_gradient_step_macros.svh"

module lrgs_assertions (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  action,
	input logic        done,
	input logic        status,
	input logic [62:0] cost
);
	import lrgs_pkg::*;

	`LRGS_ASSERT_SAME(a_done_not_busy, done, !busy, "Result strobe while the block is busy.")
	`LRGS_ASSERT_NEXT(a_step_starts, start && !busy && action == ACT_STEP, busy || done, "Step request neither started nor answered.")
	`LRGS_ASSERT_NEXT(a_load_silent, start && !busy && (action == ACT_LOAD || action == ACT_CLEAR), !busy && !done, "Load or clear request produced activity.")
	`LRGS_ASSERT_SAME(a_empty_cost, done && status, cost == '0, "Empty step reported a nonzero cost.")

endmodule

bind linear_regression_gradient_step lrgs_assertions u_lrgs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.action (action),
	.done   (done),
	.status (status),
	.cost   (cost)
);
